// File: rtl/bcmd_pkg.sv
// Shared types, constants and helpers for the balance car motor drive.
`default_nettype none
package bcmd_pkg;

  // Fixed-point format
  localparam int FracBits = 8;
  localparam int One      = 1 << FracBits;
  localparam int C7       = (7 * One + 5) / 10;   // filter weight of old speed
  localparam int C3       = (3 * One + 5) / 10;   // filter weight of new speed
  localparam int StepLo   = (6 * One + 5) / 10;
  localparam int StepHi   = 3 * One;
  localparam int StepRst  = (9 * One + 5) / 10;
  localparam int TurnNum  = 50 * One;
  localparam int TrnDiv   = 100 * One;
  localparam int TrnGain  = -1800;

  // Turn scaling: |x| / 25600 as (|x| >> 10) / 25, the divide by 25 done with a
  // reciprocal multiply; exact for pre-shifted magnitudes up to 43690, well above
  // the 36542 that the clamped target and the yaw range can reach
  localparam int TrnPreSh   = 10;
  localparam int TrnRecipSh = 18;
  localparam int TrnRecip   = ((1 << TrnRecipSh) + 24) / 25;

  // Datapath widths
  localparam int AccW  = 40;
  localparam int OpaW  = 20;
  localparam int OpbW  = 15;
  localparam int ProdW = OpaW + OpbW;
  localparam int DvdW  = 27;
  localparam int DvsW  = 17;
  localparam int RemW  = DvsW;
  localparam int CntW  = 5;
  localparam int MixW  = 32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegBalanceKp   = 3'd0,
    RegBalanceKd   = 3'd1,
    RegVelocityKp  = 3'd2,
    RegVelocityKi  = 3'd3,
    RegPwmLimit    = 3'd4,
    RegIntLimit    = 3'd5,
    RegDriveSpeed  = 3'd6,
    RegTurnLimit   = 3'd7
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [4:0] {
    StIdle, StBalA, StBalB, StEfA, StEfB, StEfC, StEfD, StInt,
    StVelA, StVelB, StVelC, StStepGo, StStepW, StTgt, StTrnA,
    StTrnB, StTrnGo, StTrnW, StMix
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

  // Arithmetic shift right that rounds toward zero
  function automatic logic signed [AccW-1:0] trunc_shr(input logic signed [AccW-1:0] v,
                                                       input logic [5:0] sh);
    logic [AccW-1:0] bias;
    bias = v[AccW-1] ? ~({AccW{1'b1}} << sh) : '0;
    trunc_shr = $signed(v + $signed(bias)) >>> sh;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bcmd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module bcmd_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bcmd_pkg::div_req_t req_i,
  output bcmd_pkg::div_rsp_t      rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [bcmd_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [bcmd_pkg::RemW-1:0]     rem_q, rem_d;
  logic [bcmd_pkg::DvdW-1:0]     quo_q, quo_d;
  logic [bcmd_pkg::DvsW-1:0]     dvs_q, dvs_d;
  logic [bcmd_pkg::RemW:0]       trial;
  logic                          fits;

  // One restoring step
  always_comb begin
    trial  = {rem_q, quo_q[bcmd_pkg::DvdW-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = bcmd_pkg::CntW'(bcmd_pkg::DvdW - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? bcmd_pkg::RemW'(trial - {1'b0, dvs_q}) : trial[bcmd_pkg::RemW-1:0];
      quo_d = {quo_q[bcmd_pkg::DvdW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// File: rtl/balance_car_motor_drive.sv
// Top level: balance, speed and turn controller for a two-wheel balancing car.
// Each request runs through the balance, speed filter, integrator, velocity and turn states;
// while turning with a nonzero entry speed the turn step also waits on the 27-step divider.
// One shared 20x15 multiplier is used eight times per request. A new request is taken only
// in the idle state; input not ready while a request works or a result is stuck.
// A finished result waits in the output register while the next request is taken.
// Reset (asynchronous, active low) restores register defaults and controller state.
`default_nettype none
module balance_car_motor_drive (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [14:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tilt_angle[16:0] tilt_rate[35:17] yaw_rate[51:36] left_count[67:52]
  // right_count[83:68] command_byte[91:84] backward_pin[92] stopped[93] working[94]
  input  wire logic [95:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // left_magnitude[12:0] left_reverse[13] right_magnitude[26:14] right_reverse[27]
  output logic [31:0]      m_axis_tdata_o
);

  // Configuration registers
  logic [9:0]  bkp_q, vkp_q, vki_q;
  logic [13:0] bkd_q;
  logic [12:0] pwm_lim_q;
  logic [14:0] int_lim_q;
  logic [7:0]  drv_spd_q;
  logic [5:0]  trn_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkp_q     <= 10'd340;
      bkd_q     <= 14'd4096;
      vkp_q     <= 10'd80;
      vki_q     <= 10'd102;
      pwm_lim_q <= 13'd7000;
      int_lim_q <= 15'd6000;
      drv_spd_q <= 8'd20;
      trn_lim_q <= 6'd30;
    end else if (cfg_we_i) begin
      unique case (bcmd_pkg::cfg_reg_e'(cfg_idx_i))
        bcmd_pkg::RegBalanceKp:  bkp_q     <= cfg_data_i[9:0];
        bcmd_pkg::RegBalanceKd:  bkd_q     <= cfg_data_i[13:0];
        bcmd_pkg::RegVelocityKp: vkp_q     <= cfg_data_i[9:0];
        bcmd_pkg::RegVelocityKi: vki_q     <= cfg_data_i[9:0];
        bcmd_pkg::RegPwmLimit:   pwm_lim_q <= cfg_data_i[12:0];
        bcmd_pkg::RegIntLimit:   int_lim_q <= cfg_data_i[14:0];
        bcmd_pkg::RegDriveSpeed: drv_spd_q <= cfg_data_i[7:0];
        bcmd_pkg::RegTurnLimit:  trn_lim_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Input field views
  logic signed [16:0] in_angle;
  logic signed [18:0] in_rate;
  logic signed [15:0] in_yaw, in_lcnt, in_rcnt;
  logic [7:0]         in_cmd;
  assign in_angle = $signed(s_axis_tdata_i[16:0]);
  assign in_rate  = $signed(s_axis_tdata_i[35:17]);
  assign in_yaw   = $signed(s_axis_tdata_i[51:36]);
  assign in_lcnt  = $signed(s_axis_tdata_i[67:52]);
  assign in_rcnt  = $signed(s_axis_tdata_i[83:68]);
  assign in_cmd   = s_axis_tdata_i[91:84];

  bcmd_pkg::state_e state_q, state_d;

  // Latched item
  logic signed [16:0] angle_q, sum_q;
  logic signed [18:0] rate_q;
  logic signed [15:0] yaw_q;
  logic               stop_q, work_q, moving_q, tl_q, tr_q;
  logic signed [8:0]  mov_q;
  logic [13:0]        amp_q;

  // Controller state
  logic signed [17:0] filt_q, filt_d;
  logic signed [15:0] integ_q, integ_d;
  logic               fwd_q, fwd_d;
  logic signed [15:0] target_q, target_d;
  logic [11:0]        step_q, step_d;
  logic               started_q, started_d;
  logic [16:0]        entry_q, entry_d;

  // Datapath registers
  logic signed [bcmd_pkg::ProdW-1:0] prod_q;
  logic signed [bcmd_pkg::AccW-1:0]  acc_q, acc_d;
  logic signed [19:0]                bal_q, bal_d;
  logic signed [29:0]                vel_q, vel_d;
  logic signed [15:0]                trn_q, trn_d;
  logic                              ovalid_q, ovalid_d;
  logic [31:0]                       odata_q, odata_d;

  // Shared multiplier operands
  logic signed [bcmd_pkg::OpaW-1:0] opa;
  logic signed [bcmd_pkg::OpbW-1:0] opb;

  bcmd_pkg::div_req_t div_req;
  bcmd_pkg::div_rsp_t div_rsp;

  bcmd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Decode of the accepted command
  logic               dec_fwd, dec_back;
  logic signed [8:0]  dec_mov;
  always_comb begin
    dec_fwd  = fwd_q;
    dec_back = s_axis_tdata_i[92];
    if (in_cmd[7]) begin
      if (in_cmd[5]) begin
        dec_fwd  = 1'b1;
        dec_back = 1'b0;
      end
      if (in_cmd[4]) begin
        dec_fwd  = 1'b0;
        dec_back = 1'b1;
      end
    end else begin
      dec_fwd  = 1'b0;
      dec_back = 1'b0;
    end
    if (dec_fwd && !dec_back)      dec_mov = -$signed({1'b0, drv_spd_q});
    else if (dec_back && !dec_fwd) dec_mov = $signed({1'b0, drv_spd_q});
    else                           dec_mov = '0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bcmd_pkg::StIdle && s_axis_tvalid_i) begin
      angle_q  <= in_angle;
      rate_q   <= in_rate;
      yaw_q    <= in_yaw;
      sum_q    <= 17'(in_lcnt) + 17'(in_rcnt);
      stop_q   <= s_axis_tdata_i[93];
      work_q   <= s_axis_tdata_i[94];
      moving_q <= dec_fwd || dec_back;
      mov_q    <= dec_mov;
      tl_q     <= in_cmd[3] && in_cmd[1];
      tr_q     <= in_cmd[3] && !in_cmd[1];
      amp_q    <= in_cmd[3] ? 14'(trn_lim_q) << bcmd_pkg::FracBits : '0;
    end
  end

  // Sequencer and datapath
  logic signed [19:0]                int_sum, int_lim;
  logic signed [17:0]                tgt_sum, tgt_lim;
  logic [bcmd_pkg::AccW-1:0]         acc_abs;
  logic signed [bcmd_pkg::MixW-1:0]  mix_l, mix_r, pwm_l;
  logic [bcmd_pkg::DvdW-1:0]         quo;

  function automatic logic signed [bcmd_pkg::MixW-1:0] clamp_mix(
      input logic signed [bcmd_pkg::MixW-1:0] v, input logic signed [bcmd_pkg::MixW-1:0] l);
    if (v > l)       clamp_mix = l;
    else if (v < -l) clamp_mix = -l;
    else             clamp_mix = v;
  endfunction

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    bal_d     = bal_q;
    vel_d     = vel_q;
    trn_d     = trn_q;
    filt_d    = filt_q;
    integ_d   = integ_q;
    fwd_d     = fwd_q;
    target_d  = target_q;
    step_d    = step_q;
    started_d = started_q;
    entry_d   = entry_q;
    ovalid_d  = ovalid_q && !m_axis_tready_i;
    odata_d   = odata_q;
    opa       = '0;
    opb       = '0;
    div_req   = '0;
    quo       = div_rsp.quotient;
    acc_abs   = acc_q[bcmd_pkg::AccW-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
    int_sum   = 20'(integ_q) + 20'(filt_q) - 20'(mov_q);
    int_lim   = $signed({5'd0, int_lim_q});
    tgt_sum   = tl_q ? 18'(target_q) - $signed({6'd0, step_q})
                     : 18'(target_q) + $signed({6'd0, step_q});
    tgt_lim   = $signed({4'd0, amp_q});
    pwm_l     = $signed({19'd0, pwm_lim_q});
    mix_l     = clamp_mix(32'(bal_q) + 32'(vel_q) - 32'(trn_q), pwm_l);
    mix_r     = clamp_mix(32'(bal_q) + 32'(vel_q) + 32'(trn_q), pwm_l);
    unique case (state_q)
      bcmd_pkg::StIdle: begin
        if (s_axis_tvalid_i) begin
          fwd_d   = dec_fwd;
          state_d = bcmd_pkg::StBalA;
        end
      end
      bcmd_pkg::StBalA: begin
        opa     = 20'(angle_q);
        opb     = $signed({5'd0, bkp_q});
        state_d = bcmd_pkg::StBalB;
      end
      bcmd_pkg::StBalB: begin
        acc_d   = bcmd_pkg::AccW'(prod_q) <<< bcmd_pkg::FracBits;
        opa     = 20'(rate_q);
        opb     = $signed({1'b0, bkd_q});
        state_d = bcmd_pkg::StEfA;
      end
      bcmd_pkg::StEfA: begin
        acc_d   = acc_q + bcmd_pkg::AccW'(prod_q);
        opa     = 20'(filt_q);
        opb     = 15'(bcmd_pkg::C7);
        state_d = bcmd_pkg::StEfB;
      end
      bcmd_pkg::StEfB: begin
        bal_d   = 20'(bcmd_pkg::trunc_shr(acc_q, 6'(2 * bcmd_pkg::FracBits)));
        acc_d   = bcmd_pkg::trunc_shr(bcmd_pkg::AccW'(prod_q), 6'(bcmd_pkg::FracBits))
                  <<< bcmd_pkg::FracBits;
        opa     = 20'(sum_q);
        opb     = 15'(bcmd_pkg::C3);
        state_d = bcmd_pkg::StEfC;
      end
      bcmd_pkg::StEfC: begin
        acc_d   = acc_q + bcmd_pkg::AccW'(prod_q);
        state_d = bcmd_pkg::StEfD;
      end
      bcmd_pkg::StEfD: begin
        filt_d  = 18'(bcmd_pkg::trunc_shr(acc_q, 6'(bcmd_pkg::FracBits)));
        state_d = bcmd_pkg::StInt;
      end
      bcmd_pkg::StInt: begin
        if (int_sum > int_lim)       integ_d = 16'(int_lim);
        else if (int_sum < -int_lim) integ_d = 16'(-int_lim);
        else                         integ_d = 16'(int_sum);
        opa     = 20'(filt_q);
        opb     = $signed({5'd0, vkp_q});
        state_d = bcmd_pkg::StVelA;
      end
      bcmd_pkg::StVelA: begin
        acc_d   = bcmd_pkg::AccW'(prod_q) <<< bcmd_pkg::FracBits;
        opa     = 20'(integ_q);
        opb     = $signed({5'd0, vki_q});
        state_d = bcmd_pkg::StVelB;
      end
      bcmd_pkg::StVelB: begin
        acc_d   = acc_q + bcmd_pkg::AccW'(prod_q);
        state_d = bcmd_pkg::StVelC;
      end
      bcmd_pkg::StVelC: begin
        vel_d = 30'(bcmd_pkg::trunc_shr(acc_q, 6'(bcmd_pkg::FracBits)));
        if (stop_q) integ_d = '0;
        if (tl_q || tr_q) begin
          if (!started_q) begin
            entry_d   = sum_q[16] ? 17'(-sum_q) : 17'(sum_q);
            started_d = 1'b1;
          end
          state_d = bcmd_pkg::StStepGo;
        end else begin
          step_d    = 12'(bcmd_pkg::StepRst);
          started_d = 1'b0;
          entry_d   = '0;
          state_d   = bcmd_pkg::StTgt;
        end
      end
      bcmd_pkg::StStepGo: begin
        if (entry_q == '0) begin
          step_d  = 12'(bcmd_pkg::StepHi);
          state_d = bcmd_pkg::StTgt;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = bcmd_pkg::DvdW'(bcmd_pkg::TurnNum);
          div_req.divisor  = entry_q;
          state_d          = bcmd_pkg::StStepW;
        end
      end
      bcmd_pkg::StStepW: begin
        if (div_rsp.done) begin
          if (quo < bcmd_pkg::DvdW'(bcmd_pkg::StepLo))      step_d = 12'(bcmd_pkg::StepLo);
          else if (quo > bcmd_pkg::DvdW'(bcmd_pkg::StepHi)) step_d = 12'(bcmd_pkg::StepHi);
          else                                              step_d = quo[11:0];
          state_d = bcmd_pkg::StTgt;
        end
      end
      bcmd_pkg::StTgt: begin
        if (!(tl_q || tr_q))         target_d = '0;
        else if (tgt_sum > tgt_lim)  target_d = 16'(tgt_lim);
        else if (tgt_sum < -tgt_lim) target_d = 16'(-tgt_lim);
        else                         target_d = 16'(tgt_sum);
        state_d = bcmd_pkg::StTrnA;
      end
      bcmd_pkg::StTrnA: begin
        opa     = 20'(target_q);
        opb     = 15'(bcmd_pkg::TrnGain);
        state_d = bcmd_pkg::StTrnB;
      end
      bcmd_pkg::StTrnB: begin
        acc_d = bcmd_pkg::AccW'(prod_q);
        if (moving_q) acc_d = bcmd_pkg::AccW'(prod_q)
                              + (bcmd_pkg::AccW'(yaw_q) <<< bcmd_pkg::FracBits);
        state_d = bcmd_pkg::StTrnGo;
      end
      // Turn scaling: magnitude >> 10, then times the reciprocal of 25
      bcmd_pkg::StTrnGo: begin
        opa     = $signed(acc_abs[bcmd_pkg::TrnPreSh +: bcmd_pkg::OpaW]);
        opb     = 15'(bcmd_pkg::TrnRecip);
        state_d = bcmd_pkg::StTrnW;
      end
      bcmd_pkg::StTrnW: begin
        trn_d   = acc_q[bcmd_pkg::AccW-1] ? -$signed(prod_q[bcmd_pkg::TrnRecipSh +: 16])
                                          : $signed(prod_q[bcmd_pkg::TrnRecipSh +: 16]);
        state_d = bcmd_pkg::StMix;
      end
      bcmd_pkg::StMix: begin
        if (!ovalid_q || m_axis_tready_i) begin
          if (!(work_q && !stop_q)) begin
            mix_l = '0;
            mix_r = '0;
          end
          odata_d[12:0]  = mix_l[bcmd_pkg::MixW-1] ? 13'(-mix_l) : 13'(mix_l);
          odata_d[13]    = !(mix_l > 0);
          odata_d[26:14] = mix_r[bcmd_pkg::MixW-1] ? 13'(-mix_r) : 13'(mix_r);
          odata_d[27]    = !(mix_r > 0);
          odata_d[31:28] = '0;
          ovalid_d       = 1'b1;
          state_d        = bcmd_pkg::StIdle;
        end
      end
      default: state_d = bcmd_pkg::StIdle;
    endcase
  end

  // Control and controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bcmd_pkg::StIdle;
      ovalid_q  <= 1'b0;
      filt_q    <= '0;
      integ_q   <= '0;
      fwd_q     <= 1'b0;
      target_q  <= '0;
      step_q    <= 12'(bcmd_pkg::StepRst);
      started_q <= 1'b0;
      entry_q   <= '0;
    end else begin
      state_q   <= state_d;
      ovalid_q  <= ovalid_d;
      filt_q    <= filt_d;
      integ_q   <= integ_d;
      fwd_q     <= fwd_d;
      target_q  <= target_d;
      step_q    <= step_d;
      started_q <= started_d;
      entry_q   <= entry_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q  <= opa * opb;
    acc_q   <= acc_d;
    bal_q   <= bal_d;
    vel_q   <= vel_d;
    trn_q   <= trn_d;
    odata_q <= odata_d;
  end

  assign s_axis_tready_o = state_q == bcmd_pkg::StIdle;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule
`default_nettype wire

// File: dv/tb_balance_car_motor_drive.sv
// Self-checking testbench for the balance car motor drive: directed and random ticks.
`timescale 1ns / 1ps
module tb_balance_car_motor_drive;

  // Input tick request
  typedef struct {
    logic signed [16:0] angle;
    logic signed [18:0] rate;
    logic signed [15:0] yaw;
    logic signed [15:0] lcnt;
    logic signed [15:0] rcnt;
    logic [7:0]         cmd;
    logic               back_pin;
    logic               stop;
    logic               work;
  } tick_t;

  // Motor drive result
  typedef struct {
    logic [12:0] lmag;
    logic        lrev;
    logic [12:0] rmag;
    logic        rrev;
  } drive_t;

  localparam logic [7:0] CmdDrive = 8'h80;
  localparam logic [7:0] CmdFwd   = 8'h20;
  localparam logic [7:0] CmdBack  = 8'h10;
  localparam logic [7:0] CmdTurn  = 8'h08;
  localparam logic [7:0] CmdLeft  = 8'h02;
  localparam int         DrainCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  balance_car_motor_drive u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of registers and controller state
  longint kp_bal, kd_bal, kp_vel, ki_vel, pwm_lim, int_lim, drv_speed, trn_lim;
  longint flt_speed, spd_int, tgt, stp, entry_spd;
  bit     fwd_flag, trn_started;

  tick_t  pending_ticks[$];
  drive_t expected_drives[$];
  int     error_count = 0;
  bit     hold_sink = 1'b0;
  int     hold_cycles = 0;

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void reset_model();
    kp_bal = 340; kd_bal = 4096; kp_vel = 80; ki_vel = 102;
    pwm_lim = 7000; int_lim = 6000; drv_speed = 20; trn_lim = 30;
    flt_speed = 0; spd_int = 0; fwd_flag = 0; tgt = 0;
    stp = bcmd_pkg::StepRst; trn_started = 0; entry_spd = 0;
  endfunction

  // Motor drives for one tick, advancing the controller state
  function automatic drive_t predict_drive(tick_t t);
    longint q, s, spd, mv, bal, vel, trn, m1, m2, amp, e1, yq;
    bit back, lft, rgt;
    drive_t d;
    q = bcmd_pkg::One;
    s = longint'(t.lcnt) + longint'(t.rcnt);
    back = t.back_pin;
    spd = 0;
    lft = 0;
    rgt = 0;
    bal = (kp_bal * longint'(t.angle) * q + kd_bal * longint'(t.rate)) / (q * q);
    if (t.cmd & CmdDrive) begin
      spd = drv_speed;
      if (t.cmd & CmdFwd) begin
        fwd_flag = 1; back = 0;
      end
      if (t.cmd & CmdBack) begin
        fwd_flag = 0; back = 1;
      end
    end else begin
      fwd_flag = 0; back = 0;
    end
    if (fwd_flag && !back) mv = -spd;
    else if (back && !fwd_flag) mv = spd;
    else mv = 0;
    e1 = (flt_speed * bcmd_pkg::C7) / q;
    flt_speed = (e1 * q + s * bcmd_pkg::C3) / q;
    spd_int = clamp_sym(spd_int + flt_speed - mv, int_lim);
    vel = (flt_speed * kp_vel * q + ki_vel * spd_int) / q;
    if (t.stop) spd_int = 0;
    amp = 0;
    if (t.cmd & CmdTurn) begin
      if (t.cmd & CmdLeft) lft = 1; else rgt = 1;
      amp = trn_lim * q;
    end
    if (lft || rgt) begin
      if (!trn_started) begin
        entry_spd = s < 0 ? -s : s;
        trn_started = 1;
      end
      stp = entry_spd > 0 ? bcmd_pkg::TurnNum / entry_spd : bcmd_pkg::StepHi;
      if (stp < bcmd_pkg::StepLo) stp = bcmd_pkg::StepLo;
      if (stp > bcmd_pkg::StepHi) stp = bcmd_pkg::StepHi;
    end else begin
      stp = bcmd_pkg::StepRst; trn_started = 0; entry_spd = 0;
    end
    if (lft) tgt -= stp;
    else if (rgt) tgt += stp;
    else tgt = 0;
    tgt = clamp_sym(tgt, amp);
    yq = (fwd_flag || back) ? longint'(t.yaw) * q : 0;
    trn = (bcmd_pkg::TrnGain * tgt + yq) / bcmd_pkg::TrnDiv;
    m1 = clamp_sym(bal + vel - trn, pwm_lim);
    m2 = clamp_sym(bal + vel + trn, pwm_lim);
    if (!(t.work && !t.stop)) begin
      m1 = 0; m2 = 0;
    end
    d.lmag = 13'(m1 < 0 ? -m1 : m1);
    d.lrev = !(m1 > 0);
    d.rmag = 13'(m2 < 0 ? -m2 : m2);
    d.rrev = !(m2 > 0);
    return d;
  endfunction

  function automatic tick_t rand_tick(bit wellformed);
    tick_t t;
    t.angle = 17'(int'($urandom_range(92160)) - 46080);
    t.rate  = 19'($urandom);
    t.yaw   = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      t.lcnt = 16'($urandom); t.rcnt = 16'($urandom);
    end else begin
      t.lcnt = 16'(int'($urandom_range(400)) - 200);
      t.rcnt = 16'(int'($urandom_range(400)) - 200);
    end
    if ($urandom_range(3) == 0) t.angle = 17'(int'($urandom_range(2560)) - 1280);
    if ($urandom_range(3) == 0) t.rate = 19'(int'($urandom_range(5120)) - 2560);
    t.cmd = 8'($urandom);
    if (wellformed) t.cmd = t.cmd | CmdDrive;
    t.back_pin = 1'($urandom_range(1));
    t.stop = ($urandom_range(7) == 0);
    t.work = ($urandom_range(7) != 0);
    return t;
  endfunction

  task automatic write_reg(bcmd_pkg::cfg_reg_e idx, int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 15'(val);
    case (idx)
      bcmd_pkg::RegBalanceKp:  kp_bal = val;
      bcmd_pkg::RegBalanceKd:  kd_bal = val;
      bcmd_pkg::RegVelocityKp: kp_vel = val;
      bcmd_pkg::RegVelocityKi: ki_vel = val;
      bcmd_pkg::RegPwmLimit:   pwm_lim = val;
      bcmd_pkg::RegIntLimit:   int_lim = val;
      bcmd_pkg::RegDriveSpeed: drv_speed = val;
      default:                 trn_lim = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for all requests and results to finish, plus latency margin
  task automatic wait_idle();
    wait (pending_ticks.size() == 0 && expected_drives.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, int got, int exp);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    error_count++;
  endtask

  // Driver: feeds queued ticks with random gaps
  int gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_drives.push_back(predict_drive(pending_ticks.pop_front()));
      gap = $urandom_range(1) ? 0 : $urandom_range(7);
    end
    if (gap > 0) begin
      gap--;
      s_axis_tvalid_i <= 1'b0;
    end else if (pending_ticks.size() > 0 && rst_ni) begin
      tick_t t;
      t = pending_ticks[0];
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= {1'b0, t.work, t.stop, t.back_pin, t.cmd, t.rcnt, t.lcnt,
                          t.yaw, t.rate, t.angle};
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Monitor: checks results and drives ready with random stalls
  int stall = 0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      drive_t e;
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected result", int'(m_axis_tdata_o), 0);
      end else begin
        e = expected_drives.pop_front();
        if (m_axis_tdata_o[12:0] != e.lmag)
          report_mismatch("left_magnitude", int'(m_axis_tdata_o[12:0]), int'(e.lmag));
        if (m_axis_tdata_o[13] != e.lrev)
          report_mismatch("left_reverse", int'(m_axis_tdata_o[13]), int'(e.lrev));
        if (m_axis_tdata_o[26:14] != e.rmag)
          report_mismatch("right_magnitude", int'(m_axis_tdata_o[26:14]), int'(e.rmag));
        if (m_axis_tdata_o[27] != e.rrev)
          report_mismatch("right_reverse", int'(m_axis_tdata_o[27]), int'(e.rrev));
      end
      stall = $urandom_range(1) ? 0 : $urandom_range(7);
    end
    if (hold_sink) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      hold_sink   <= 1'b1;
    end else begin
      hold_sink <= 1'b0;
    end
  end

  // Stimulus
  initial begin
    tick_t t;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every command bit, turn entry cases
    t = '{17'sd46080, 19'h3FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h00, 1'b1, 1'b0, 1'b1};
    pending_ticks.push_back(t);
    t = '{-17'sd46080, 19'h40000, 16'h8000, 16'h8000, 16'h8000, 8'hFF, 1'b0, 1'b0, 1'b1};
    pending_ticks.push_back(t);
    t = '{17'sd0, 19'sd0, 16'sd0, 16'sd0, 16'sd0, CmdDrive | CmdFwd, 1'b1, 1'b0, 1'b1};
    pending_ticks.push_back(t);
    t = '{17'sd256, 19'sd100, 16'sd5000, 16'sd1, 16'sd2,
          CmdDrive | CmdFwd | CmdBack, 1'b0, 1'b0, 1'b1};
    pending_ticks.push_back(t);
    t = '{17'sd256, 19'sd100, 16'sd5000, 16'sd3, 16'sd2, CmdDrive, 1'b1, 1'b0, 1'b1};
    pending_ticks.push_back(t);
    t = '{17'sd256, 19'sd100, 16'sd5000, 16'sd3, 16'sd2, CmdDrive, 1'b0, 1'b0, 1'b1};
    pending_ticks.push_back(t);
    // Turn with zero entry speed, then left, then a fast entry speed
    t = '{17'sd0, 19'sd0, 16'sd0, 16'sd0, 16'sd0, CmdDrive | CmdTurn, 1'b0, 1'b0, 1'b1};
    repeat (4) pending_ticks.push_back(t);
    t = '{17'sd0, 19'sd0, 16'sd300, 16'sd50, 16'sd50, CmdTurn | CmdLeft, 1'b0, 1'b0, 1'b1};
    repeat (3) pending_ticks.push_back(t);
    t = '{17'sd0, 19'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 1'b0, 1'b1};
    pending_ticks.push_back(t);
    t = '{17'sd0, 19'sd0, 16'sd300, -16'sd900, 16'sd0, CmdDrive | CmdTurn | CmdBack,
          1'b0, 1'b0, 1'b1};
    repeat (3) pending_ticks.push_back(t);
    t = '{17'sd1000, 19'sd0, 16'sd0, 16'sd10, 16'sd10, 8'h00, 1'b0, 1'b1, 1'b1};
    pending_ticks.push_back(t);
    t = '{17'sd1000, 19'sd0, 16'sd0, 16'sd10, 16'sd10, 8'h00, 1'b0, 1'b0, 1'b0};
    pending_ticks.push_back(t);
    t = '{17'sd1000, 19'sd0, 16'sd0, 16'sd10, 16'sd10, 8'h00, 1'b0, 1'b1, 1'b0};
    pending_ticks.push_back(t);
    wait_idle();

    // Phases over register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: begin
          write_reg(bcmd_pkg::RegBalanceKp, 1023); write_reg(bcmd_pkg::RegBalanceKd, 16383);
          write_reg(bcmd_pkg::RegVelocityKp, 1023); write_reg(bcmd_pkg::RegVelocityKi, 1023);
          write_reg(bcmd_pkg::RegPwmLimit, 8191); write_reg(bcmd_pkg::RegIntLimit, 32767);
          write_reg(bcmd_pkg::RegDriveSpeed, 255); write_reg(bcmd_pkg::RegTurnLimit, 63);
        end
        2: begin
          write_reg(bcmd_pkg::RegBalanceKp, 0); write_reg(bcmd_pkg::RegBalanceKd, 0);
          write_reg(bcmd_pkg::RegVelocityKp, 0); write_reg(bcmd_pkg::RegVelocityKi, 0);
          write_reg(bcmd_pkg::RegPwmLimit, 0); write_reg(bcmd_pkg::RegIntLimit, 0);
          write_reg(bcmd_pkg::RegDriveSpeed, 0); write_reg(bcmd_pkg::RegTurnLimit, 0);
        end
        3, 4, 5: begin
          write_reg(bcmd_pkg::RegBalanceKp, $urandom_range(1023));
          write_reg(bcmd_pkg::RegBalanceKd, $urandom_range(16383));
          write_reg(bcmd_pkg::RegVelocityKp, $urandom_range(1023));
          write_reg(bcmd_pkg::RegVelocityKi, $urandom_range(1023));
          write_reg(bcmd_pkg::RegPwmLimit, $urandom_range(8191));
          write_reg(bcmd_pkg::RegIntLimit, $urandom_range(32767));
          write_reg(bcmd_pkg::RegDriveSpeed, $urandom_range(255));
          write_reg(bcmd_pkg::RegTurnLimit, $urandom_range(63));
        end
        6: begin
          write_reg(bcmd_pkg::RegBalanceKp, 340); write_reg(bcmd_pkg::RegBalanceKd, 4096);
          write_reg(bcmd_pkg::RegVelocityKp, 80); write_reg(bcmd_pkg::RegVelocityKi, 102);
          write_reg(bcmd_pkg::RegPwmLimit, 7000); write_reg(bcmd_pkg::RegIntLimit, 6000);
          write_reg(bcmd_pkg::RegDriveSpeed, 20); write_reg(bcmd_pkg::RegTurnLimit, 30);
        end
        default: ;
      endcase
      // Mostly well-formed drive/turn runs with random content, some noise
      for (int i = 0; i < 100; i++) pending_ticks.push_back(rand_tick($urandom_range(4) != 0));
      if (ph == 3) begin
        wait (pending_ticks.size() < 90);
        hold_cycles = 2000;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
